// File: rtl/core/hssc_pkg.sv
// ----------------------------------------------------------------------------
// hssc_pkg
// Types, codes and commutation table for the hall six-step commutator.
// ----------------------------------------------------------------------------
package hssc_pkg;

  localparam int unsigned DutyW   = 10;
  localparam int unsigned CountW  = 32;
  localparam logic [DutyW-1:0] DutyMax = 10'd1000;

  typedef enum logic [1:0] {
    KIND_HALL  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_DUTY  = 2'd3
  } kind_t;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_U    = 2'd1;
  localparam logic [1:0] PHASE_V    = 2'd2;
  localparam logic [1:0] PHASE_W    = 2'd3;

  localparam logic [2:0] LOW_OFF = 3'b000;
  localparam logic [2:0] LOW_U   = 3'b001;
  localparam logic [2:0] LOW_V   = 3'b010;
  localparam logic [2:0] LOW_W   = 3'b100;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  hall_raw;
    logic [1:0]  dir;
    logic [15:0] duty_request;
  } item_t;

  typedef struct packed {
    logic              status;
    logic              running;
    logic [2:0]        hall_code;
    logic [1:0]        high_phase;
    logic [DutyW-1:0]  compare_value;
    logic [2:0]        low_enable;
    logic [CountW-1:0] commutations;
  } result_t;

  typedef struct packed {
    logic              run_flag;
    logic [1:0]        rotation_dir;
    logic [DutyW-1:0]  duty_level;
    logic [2:0]        hall_now;
    logic [1:0]        high_sel;
    logic [2:0]        low_sel;
    logic [CountW-1:0] commutation_count;
    logic [DutyW-1:0]  cmp_level;
  } state_t;

  function automatic logic code_valid(input logic [2:0] code);
    return (code != 3'd0) && (code != 3'd7);
  endfunction

  function automatic logic [1:0] high_of_code(input logic [2:0] code);
    logic [1:0] ph;
    case (code)
      3'd1:    ph = PHASE_U;
      3'd2:    ph = PHASE_V;
      3'd3:    ph = PHASE_V;
      3'd4:    ph = PHASE_W;
      3'd5:    ph = PHASE_U;
      3'd6:    ph = PHASE_W;
      default: ph = PHASE_NONE;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] low_of_code(input logic [2:0] code);
    logic [2:0] en;
    case (code)
      3'd1:    en = LOW_W;
      3'd2:    en = LOW_U;
      3'd3:    en = LOW_W;
      3'd4:    en = LOW_V;
      3'd5:    en = LOW_V;
      3'd6:    en = LOW_U;
      default: en = LOW_OFF;
    endcase
    return en;
  endfunction

  function automatic logic [DutyW-1:0] clamp_duty(input logic [15:0] req);
    return (req > 16'(DutyMax)) ? DutyMax : req[DutyW-1:0];
  endfunction

endpackage

// File: rtl/core/hssc_step.sv
// ----------------------------------------------------------------------------
// hssc_step
// Next-state and result logic for one commutator transaction.
// ----------------------------------------------------------------------------
module hssc_step (
  input  hssc_pkg::state_t  st,
  input  hssc_pkg::item_t   item,
  output hssc_pkg::state_t  st_next,
  output hssc_pkg::result_t res
);
  import hssc_pkg::*;

  logic [2:0]       code_cur;
  logic [2:0]       code_new;
  logic [DutyW-1:0] duty_new;
  logic             status;

  assign code_cur = (st.rotation_dir == DIR_CCW) ? (3'd7 - item.hall_raw) : item.hall_raw;
  assign code_new = (item.dir == DIR_CCW) ? (3'd7 - item.hall_raw) : item.hall_raw;
  assign duty_new = clamp_duty(item.duty_request);

  always_comb begin
    st_next = st;
    status  = 1'b0;
    case (item.kind)
      KIND_HALL: begin
        if (st.run_flag) begin
          st_next.hall_now = code_cur;
          if (code_valid(code_cur)) begin
            st_next.high_sel          = high_of_code(code_cur);
            st_next.low_sel           = low_of_code(code_cur);
            st_next.cmp_level         = st.duty_level;
            st_next.commutation_count = st.commutation_count + CountW'(1);
          end
        end
      end
      KIND_START: begin
        if (item.dir == DIR_STOP) begin
          st_next.run_flag   = 1'b0;
          st_next.duty_level = '0;
          st_next.high_sel   = PHASE_NONE;
          st_next.low_sel    = LOW_OFF;
          st_next.cmp_level  = '0;
        end else begin
          st_next.rotation_dir = item.dir;
          st_next.duty_level   = duty_new;
          st_next.hall_now     = code_new;
          if (code_valid(code_new)) begin
            st_next.run_flag  = 1'b1;
            st_next.high_sel  = high_of_code(code_new);
            st_next.low_sel   = low_of_code(code_new);
            st_next.cmp_level = duty_new;
          end else begin
            st_next.run_flag  = 1'b0;
            st_next.high_sel  = PHASE_NONE;
            st_next.low_sel   = LOW_OFF;
            st_next.cmp_level = '0;
            status            = 1'b1;
          end
        end
      end
      KIND_STOP: begin
        st_next.run_flag   = 1'b0;
        st_next.duty_level = '0;
        st_next.high_sel   = PHASE_NONE;
        st_next.low_sel    = LOW_OFF;
        st_next.cmp_level  = '0;
      end
      KIND_DUTY: begin
        st_next.duty_level = duty_new;
        if (st.run_flag && code_valid(st.hall_now)) begin
          st_next.cmp_level = duty_new;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_comb begin
    res.status        = status;
    res.running       = st_next.run_flag;
    res.hall_code     = st_next.hall_now;
    res.high_phase    = st_next.high_sel;
    res.compare_value = (st_next.high_sel != PHASE_NONE) ? st_next.cmp_level : '0;
    res.low_enable    = st_next.low_sel;
    res.commutations  = st_next.commutation_count;
  end

endmodule

// File: rtl/core/hall_six_step_commutator.sv
// ----------------------------------------------------------------------------
// hall_six_step_commutator
// Six-step BLDC commutation from hall events, start/stop and duty commands.
// ----------------------------------------------------------------------------
// path: an accepted transaction is held in the input register, then
//   its result is written to the result register
// throughput: one transaction per cycle while no result is held, set by the state update
// stalls: a held result holds the input register, which holds item_ready low
// reset: clears drive, duty, direction, hall code and commutation count
module hall_six_step_commutator (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  hssc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output hssc_pkg::result_t result
);
  import hssc_pkg::*;

  logic    stage_valid;
  item_t   stage_item;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  logic    advance;

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;

  hssc_step u_step (
    .st      (st),
    .item    (stage_item),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        st <= st_next;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res_next;
    end
  end

  a_low_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0(result.low_enable))
    else $error("low-side enables not one-hot");

  a_drive_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.high_phase == PHASE_NONE) == (result.low_enable == LOW_OFF)))
    else $error("high and low drive disagree");

  a_cmp_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.high_phase == PHASE_NONE) |-> (result.compare_value == '0))
    else $error("compare level set with no phase driven");

  a_status_stop: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |-> !result.running)
    else $error("start error while running");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (st.commutation_count != $past(st.commutation_count)) |->
      (st.commutation_count == $past(st.commutation_count) + CountW'(1)))
    else $error("commutation count jumped");

endmodule
